// File: src/histogram_quartile_engine_assert.svh
// assertion macros for the histogram quartile engine modules, used by hqe_ctrl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef HISTOGRAM_QUARTILE_ENGINE_ASSERT_SVH
`define HISTOGRAM_QUARTILE_ENGINE_ASSERT_SVH

// same-cycle implication, held off during reset
`define HQE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define HQE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hqe_pkg.sv
// shared types and constants for the histogram quartile engine
// no dependencies
`default_nettype none

package hqe_pkg;

    // default sizes of the bin store
    localparam int BINS_DEF       = 256;
    localparam int COUNT_BITS_DEF = 32;

    // fixed field widths of the stream items
    localparam int OP_W        = 3;
    localparam int BIN_W       = 8;
    localparam int VAL_W       = 32;
    localparam int Q_W         = 2;
    localparam int OUT_CNT_W   = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_ADD   = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_FIND  = 3'd4
    } t_op;

    // quartile codes, anything above the median means third quartile
    typedef enum logic [Q_W-1:0] {
        Q_FIRST  = 2'd0,
        Q_MEDIAN = 2'd1,
        Q_THIRD  = 2'd2
    } t_quart;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_WR,
        S_RD,
        S_ADD,
        S_NOP,
        S_TWAIT,
        S_TACC,
        S_TGT,
        S_SWAIT,
        S_SACC,
        S_SDIST,
        S_SCMP,
        S_FIN,
        S_OUT
    } t_state;

    // shared arithmetic unit modes
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_ABSDIFF,
        ALU_CMP
    } t_alu_mode;

    // store control from the sequencer
    typedef struct packed {
        logic wr;
        logic clr;
    } t_store_ctl;

    // compare flags from the shared unit
    typedef struct packed {
        logic lt;
        logic eq;
    } t_alu_flags;

endpackage

`default_nettype wire

// File: src/hqe_alu.sv
// shared wide arithmetic unit: add, absolute difference, compare
// depends on hqe_pkg
`default_nettype none

module hqe_alu
    import hqe_pkg::*;
#(
    parameter int W = 42
) (
    input  var t_alu_mode  i_mode,
    input  wire [W-1:0]    i_a,
    input  wire [W-1:0]    i_b,
    output logic [W-1:0]   o_res,
    output t_alu_flags     o_flags
);

    logic a_lt_b;

    // compare is always available alongside the result
    assign a_lt_b     = (i_a < i_b);
    assign o_flags.lt = a_lt_b;
    assign o_flags.eq = (i_a == i_b);

    // result by mode
    always_comb begin
        case (i_mode)
            ALU_ADD:     o_res = i_a + i_b;
            ALU_ABSDIFF: o_res = a_lt_b ? (i_b - i_a) : (i_a - i_b);
            ALU_CMP:     o_res = '0;
            default:     o_res = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/hqe_store.sv
// bin count memory with registered read and per-bin valid bits
// depends on hqe_pkg
`default_nettype none

module hqe_store
    import hqe_pkg::*;
#(
    parameter int BINS       = BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  var t_store_ctl           i_ctl,
    input  wire [$clog2(BINS)-1:0]   i_addr,
    input  wire [COUNT_BITS-1:0]     i_wdata,
    output logic [COUNT_BITS-1:0]    o_count
);

    logic [COUNT_BITS-1:0] mem [BINS];
    logic [BINS-1:0]       r_valid;
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  r_rvld;

    // single port memory, read data registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    // valid bits: cleared by reset and by the clear operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr) begin
                r_valid[i_addr] <= 1'b1;
            end
            r_rvld <= r_valid[i_addr];
        end
    end

    // a bin never written since the last clear reads as zero
    assign o_count = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

// File: src/hqe_ctrl.sv
// sequencer and datapath registers of the histogram quartile engine
// depends on hqe_pkg, drives hqe_store and hqe_alu, asserts via the macro header
`default_nettype none
`include "histogram_quartile_engine_assert.svh"

module hqe_ctrl
    import hqe_pkg::*;
#(
    parameter int BINS       = BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    // input item
    input  wire                                        i_s_tvalid,
    output logic                                       o_s_tready,
    input  wire [OP_W-1:0]                             i_op,
    input  wire [BIN_W-1:0]                            i_bin_index,
    input  wire [VAL_W-1:0]                            i_value,
    input  wire [Q_W-1:0]                              i_quartile,
    input  wire [BIN_W-1:0]                            i_range_low,
    input  wire [BIN_W-1:0]                            i_range_high,
    // result item
    output logic                                       o_m_tvalid,
    input  wire                                        i_m_tready,
    output logic [OUT_CNT_W-1:0]                       o_bin_count,
    output logic [BIN_W-1:0]                           o_found_bin,
    output logic                                       o_range_error,
    // bin store
    output t_store_ctl                                 o_st_ctl,
    output logic [$clog2(BINS)-1:0]                    o_st_addr,
    output logic [COUNT_BITS-1:0]                      o_st_wdata,
    input  wire [COUNT_BITS-1:0]                       i_st_count,
    // shared arithmetic unit
    output t_alu_mode                                  o_alu_mode,
    output logic [COUNT_BITS+$clog2(BINS)+1:0]         o_alu_a,
    output logic [COUNT_BITS+$clog2(BINS)+1:0]         o_alu_b,
    input  wire [COUNT_BITS+$clog2(BINS)+1:0]          i_alu_res,
    input  var t_alu_flags                             i_alu_flags
);

    localparam int IDX_W = $clog2(BINS);
    localparam int SUM_W = COUNT_BITS + IDX_W + 2;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx, r_lo, r_hi, r_start;
    logic [Q_W-1:0]         r_q;
    logic [COUNT_BITS-1:0]  r_val;
    logic                   r_inrange;
    logic [SUM_W-1:0]       r_sum, r_tgt, r_d, r_best;
    logic [BIN_W-1:0]       r_fbin;
    logic                   r_err;
    logic [OUT_CNT_W-1:0]   r_res_count;
    logic                   r_ovld;
    logic [OUT_CNT_W-1:0]   r_o_count;
    logic [BIN_W-1:0]       r_o_bin;
    logic                   r_o_err;

    logic                   fin;
    logic                   slot_free;
    logic                   accept;
    logic                   find_err;
    logic [IDX_W-1:0]       lo_sat, hi_sat;
    logic [COUNT_BITS-1:0]  val_cb;
    logic [COUNT_BITS+VAL_W-1:0] val_ext;
    logic [COUNT_BITS+OUT_CNT_W-1:0] cnt_ext;
    logic [OUT_CNT_W-1:0]   res_count;
    logic [SUM_W-1:0]       cnt_w;
    logic [IDX_W-1:0]       diff, part, start_calc;
    logic [IDX_W+1:0]       diff3;
    logic [SUM_W-1:0]       tgt_calc;
    logic                   take;

    // input decode
    assign accept   = i_s_tvalid && o_s_tready;
    assign find_err = (i_op == OP_FIND) && (i_range_low > i_range_high);
    assign lo_sat   = ({1'b0, i_range_low} > 9'(BINS - 1)) ? IDX_W'(BINS - 1)
                                                          : i_range_low[IDX_W-1:0];
    assign hi_sat   = ({1'b0, i_range_high} > 9'(BINS - 1)) ? IDX_W'(BINS - 1)
                                                           : i_range_high[IDX_W-1:0];
    assign val_ext  = {{COUNT_BITS{1'b0}}, i_value};
    assign val_cb   = val_ext[COUNT_BITS-1:0];

    // store count views
    assign cnt_ext   = {{OUT_CNT_W{1'b0}}, i_st_count};
    assign cnt_w     = SUM_W'(i_st_count);
    assign res_count = ((r_state == S_RD) && r_inrange) ? cnt_ext[OUT_CNT_W-1:0] : '0;
    assign slot_free = !r_ovld || i_m_tready;

    // search start bin and target
    assign diff  = r_hi - r_lo;
    assign diff3 = {2'b00, diff} + {1'b0, diff, 1'b0};
    always_comb begin
        case (r_q)
            Q_FIRST:  part = diff >> 2;
            Q_MEDIAN: part = diff >> 1;
            default:  part = IDX_W'(diff3 >> 2);
        endcase
    end
    assign start_calc = r_lo + part;
    assign tgt_calc   = (r_q == Q_MEDIAN) ? (i_alu_res >> 1) : (i_alu_res >> 2);

    // strictly better wins; a tie goes to the last tied bin up to the start
    assign take = (r_idx == r_lo) || i_alu_flags.lt || (i_alu_flags.eq && (r_idx <= r_start));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_op)
                        OP_CLEAR: n_state = S_CLR;
                        OP_ADD:   n_state = S_ADD;
                        OP_WRITE: n_state = S_WR;
                        OP_READ:  n_state = S_RD;
                        OP_FIND:  n_state = find_err ? S_NOP : S_TWAIT;
                        default:  n_state = S_NOP;
                    endcase
                end
            end
            S_CLR, S_WR, S_RD, S_ADD, S_NOP, S_FIN: begin
                n_state = slot_free ? S_IDLE : S_OUT;
            end
            S_TWAIT: n_state = S_TACC;
            S_TACC:  n_state = (r_idx == r_hi) ? S_TGT : S_TWAIT;
            S_TGT:   n_state = S_SWAIT;
            S_SWAIT: n_state = S_SACC;
            S_SACC:  n_state = S_SDIST;
            S_SDIST: n_state = S_SCMP;
            S_SCMP:  n_state = (r_idx == r_hi) ? S_FIN : S_SWAIT;
            S_OUT:   n_state = slot_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: handshake, store control, unit operands
    always_comb begin
        o_s_tready = 1'b0;
        fin        = 1'b0;
        o_st_ctl   = '0;
        o_st_addr  = r_idx;
        o_st_wdata = r_val;
        o_alu_mode = ALU_ADD;
        o_alu_a    = r_sum;
        o_alu_b    = cnt_w;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_st_addr  = i_bin_index[IDX_W-1:0];
            end
            S_CLR: begin
                o_st_ctl.clr = 1'b1;
                fin          = 1'b1;
            end
            S_WR: begin
                o_st_ctl.wr = r_inrange;
                fin         = 1'b1;
            end
            S_ADD: begin
                o_alu_a     = cnt_w;
                o_alu_b     = SUM_W'(r_val);
                o_st_wdata  = i_alu_res[COUNT_BITS-1:0];
                o_st_ctl.wr = r_inrange;
                fin         = 1'b1;
            end
            S_RD, S_NOP, S_FIN: begin
                fin = 1'b1;
            end
            S_TGT: begin
                o_alu_b = ((r_q == Q_FIRST) || (r_q == Q_MEDIAN)) ? '0
                                                                  : {r_sum[SUM_W-2:0], 1'b0};
            end
            S_SDIST: begin
                o_alu_mode = ALU_ABSDIFF;
                o_alu_a    = r_tgt;
                o_alu_b    = r_sum;
            end
            S_SCMP: begin
                o_alu_mode = ALU_CMP;
                o_alu_a    = r_d;
                o_alu_b    = r_best;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((fin || (r_state == S_OUT)) && slot_free) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // item capture and search datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx     <= (i_op == OP_FIND) ? lo_sat : i_bin_index[IDX_W-1:0];
            r_lo      <= lo_sat;
            r_hi      <= hi_sat;
            r_q       <= i_quartile;
            r_val     <= val_cb;
            r_inrange <= ({1'b0, i_bin_index} < 9'(BINS));
            r_sum     <= '0;
            r_err     <= find_err;
            r_fbin    <= find_err ? i_range_low : '0;
        end
        case (r_state)
            S_TACC: begin
                r_sum <= i_alu_res;
                if (r_idx != r_hi) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            S_TGT: begin
                r_tgt   <= tgt_calc;
                r_start <= start_calc;
                r_idx   <= r_lo;
                r_sum   <= '0;
            end
            S_SACC: begin
                r_sum <= i_alu_res;
            end
            S_SDIST: begin
                r_d <= i_alu_res;
            end
            S_SCMP: begin
                if (take) begin
                    r_best <= r_d;
                    r_fbin <= BIN_W'(r_idx);
                end
                if (r_idx != r_hi) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            default: ;
        endcase
        if (fin) begin
            r_res_count <= res_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((fin || (r_state == S_OUT)) && slot_free) begin
            r_o_count <= fin ? res_count : r_res_count;
            r_o_bin   <= r_fbin;
            r_o_err   <= r_err;
        end
    end

    assign o_m_tvalid    = r_ovld;
    assign o_bin_count   = r_o_count;
    assign o_found_bin   = r_o_bin;
    assign o_range_error = r_o_err;

    // checks on the search sequencing
    `HQE_ASSERT_IMP(a_idx_in_range, (r_state == S_SACC), ((r_idx >= r_lo) && (r_idx <= r_hi)), "search index left the range")
    `HQE_ASSERT_IMP(a_start_in_range, (r_state == S_SWAIT), ((r_start >= r_lo) && (r_start <= r_hi)), "start bin outside the range")
    `HQE_ASSERT_IMP(a_found_in_range, (r_state == S_FIN), ((r_fbin >= BIN_W'(r_lo)) && (r_fbin <= BIN_W'(r_hi))), "found bin outside the range")
    `HQE_ASSERT_NXT(a_best_monotone, ((r_state == S_SCMP) && (r_idx != r_lo)), (r_best <= $past(r_best)), "best distance grew")

endmodule

`default_nettype wire

// File: src/histogram_quartile_engine.sv
// Histogram quartile engine: a store of BINS counts with clear, add, write,
// read and quartile search operations, one result item per input item.
// Input channel i_s_*: one operation per item, accepted when tvalid and tready
// are both high; tready is high only while the sequencer is idle, and stays
// high while an earlier result still waits in the output register.
// Output channel o_m_*: one result item per input item, held in an output
// register until the receiver takes it; a stalled receiver holds the sequencer
// only when a second result is finished before the first is taken.
// Clear, write, read and add take the accept cycle (one memory read) and an
// operation state (one write or read-out). A quartile search over the bins
// from low to high takes the accept cycle, a summing pass (wait, accumulate
// per bin), a target step, a scoring pass (wait, accumulate, distance, compare
// per bin) and a finish step, paced by the single registered memory port and
// the one shared wide add/subtract/compare unit. A reversed range skips the
// search and answers with range_error set.
// Reset (synchronous, active low) clears all bin counts at once through
// per-bin valid bits; no clearing pass is needed and items are taken in the
// cycle after reset is released. The clear operation works the same way.
// Depends on hqe_pkg, hqe_alu, hqe_store and hqe_ctrl.
`default_nettype none

module histogram_quartile_engine
    import hqe_pkg::*;
#(
    parameter int BINS       = BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // op[2:0], bin_index[10:3], value[42:11], quartile[44:43],
    // range_low[52:45], range_high[60:53], zero fill[63:61]
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // bin_count[31:0], found_bin[39:32], range_error[40], zero fill[47:41]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = $clog2(BINS);
    localparam int SUM_W = COUNT_BITS + IDX_W + 2;

    t_store_ctl            st_ctl;
    logic [IDX_W-1:0]      st_addr;
    logic [COUNT_BITS-1:0] st_wdata;
    logic [COUNT_BITS-1:0] st_count;
    t_alu_mode             alu_mode;
    logic [SUM_W-1:0]      alu_a, alu_b, alu_res;
    t_alu_flags            alu_flags;
    logic [OUT_CNT_W-1:0]  bin_count;
    logic [BIN_W-1:0]      found_bin;
    logic                  range_error;

    // bin store
    hqe_store #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (st_ctl),
        .i_addr  (st_addr),
        .i_wdata (st_wdata),
        .o_count (st_count)
    );

    // shared arithmetic unit
    hqe_alu #(
        .W (SUM_W)
    ) u_alu (
        .i_mode  (alu_mode),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    // sequencer
    hqe_ctrl #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_op          (i_s_tdata[2:0]),
        .i_bin_index   (i_s_tdata[10:3]),
        .i_value       (i_s_tdata[42:11]),
        .i_quartile    (i_s_tdata[44:43]),
        .i_range_low   (i_s_tdata[52:45]),
        .i_range_high  (i_s_tdata[60:53]),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_bin_count   (bin_count),
        .o_found_bin   (found_bin),
        .o_range_error (range_error),
        .o_st_ctl      (st_ctl),
        .o_st_addr     (st_addr),
        .o_st_wdata    (st_wdata),
        .i_st_count    (st_count),
        .o_alu_mode    (alu_mode),
        .o_alu_a       (alu_a),
        .o_alu_b       (alu_b),
        .i_alu_res     (alu_res),
        .i_alu_flags   (alu_flags)
    );

    // result packing
    assign o_m_tdata = {7'b0, range_error, found_bin, bin_count};

endmodule

`default_nettype wire
